FILE: rtl/utf8_stream_decoder_core_assert.svh
// Assertion macros for the checker file u8sd_chk
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define U8SD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define U8SD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/u8sd_pkg.sv
package u8sd_pkg;

   localparam int CODE_W = 21;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 1;

   localparam logic [IDX_W-1:0] CSR_FALLBACK = 1'b0;
   localparam logic [IDX_W-1:0] CSR_REPL     = 1'b1;

   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_CTRL  = 1'b1;

   localparam logic [CODE_W-1:0] REPL_RESET = 21'd63;

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] DEL_BYTE   = 8'h7f;
   localparam logic [7:0] LEAD_MIN   = 8'hc2;
   localparam logic [7:0] LEAD_MAX   = 8'hf4;
   localparam logic [7:0] LEAD_E0    = 8'he0;
   localparam logic [7:0] LEAD_ED    = 8'hed;
   localparam logic [7:0] LEAD_F0    = 8'hf0;
   localparam logic [7:0] LEAD_F4    = 8'hf4;
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] CONT_MAX   = 8'hbf;
   localparam logic [7:0] E0_MIN     = 8'ha0;
   localparam logic [7:0] ED_MAX     = 8'h9f;
   localparam logic [7:0] F0_MIN     = 8'h90;
   localparam logic [7:0] F4_MAX     = 8'h8f;

   typedef struct packed {
      logic take;    // accept a beat that needs no replay
      logic hold;    // accept a beat that breaks the pending sequence
      logic replay;  // emit the pending byte at the replay index
      logic tail;    // emit the result of the held byte
   } cmd_type;

   typedef struct packed {
      logic need_replay;
      logic replay_last;
      logic tail_emits;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic              emit;
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              lead;
   } idle_res_type;

   // Pending bytes are always 0x80 and above, so only the two wide cases remain
   function automatic logic [CODE_W-1:0] invalid_code(logic [7:0] b, logic fb,
                                                      logic [CODE_W-1:0] repl);
      logic [CODE_W-1:0] res;
      if (fb) begin
         res = {{(CODE_W-BYTE_W){1'b0}}, b};
      end else begin
         res = repl;
      end
      return res;
   endfunction

   function automatic idle_res_type idle_decode(logic [7:0] b, logic fb,
                                                logic [CODE_W-1:0] repl);
      idle_res_type res;
      res.emit = 1'b0;
      res.kind = KIND_PRINT;
      res.code = {{(CODE_W-BYTE_W){1'b0}}, b};
      res.lead = 1'b0;
      if (b < CTRL_LIMIT) begin
         res.emit = 1'b1;
         res.kind = KIND_CTRL;
      end else if (b < DEL_BYTE) begin
         res.emit = 1'b1;
      end else if (b == DEL_BYTE) begin
         res.emit = 1'b0;
      end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
         res.lead = 1'b1;
      end else begin
         res.emit = 1'b1;
         res.code = invalid_code(b, fb, repl);
      end
      return res;
   endfunction

endpackage

FILE: rtl/u8sd_ctrl.sv
module u8sd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  u8sd_pkg::sts_type sts,
   output u8sd_pkg::cmd_type cmd
);
   import u8sd_pkg::*;

   typedef enum logic [2:0] {
      ST_TAKE   = 3'b001,
      ST_REPLAY = 3'b010,
      ST_TAIL   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_TAKE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               if (sts.need_replay) begin
                  cmd.hold = 1'b1;
                  state_in = ST_REPLAY;
               end else begin
                  cmd.take = 1'b1;
               end
            end
         end
         ST_REPLAY: begin
            if (sts.out_free) begin
               cmd.replay = 1'b1;
               if (sts.replay_last) begin
                  state_in = sts.tail_emits ? ST_TAIL : ST_TAKE;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.tail = 1'b1;
               state_in = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/u8sd_dpath.sv
module u8sd_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_in_byte,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_kind,
   output logic [u8sd_pkg::CODE_W-1:0]   rsp_code,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic [u8sd_pkg::IDX_W-1:0]    csr_index,
   input  logic [u8sd_pkg::CODE_W-1:0]   csr_wdata,
   input  u8sd_pkg::cmd_type             cmd,
   output u8sd_pkg::sts_type             sts
);
   import u8sd_pkg::*;

   logic              fb_ff, fb_in;
   logic [CODE_W-1:0] repl_ff, repl_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [1:0]        idx_ff, idx_in;
   logic [7:0]        pend_ff [3];
   logic [7:0]        pend_in [3];
   logic [7:0]        held_ff, held_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic              out_last_ff, out_last_in;

   logic [7:0]   b, lead, sec, rep_byte;
   logic         cont, bad3, bad4;
   idle_res_type in_res, held_res;

   assign b        = req_in_byte;
   assign lead     = pend_ff[0];
   assign sec      = pend_ff[1];
   assign cont     = (b[7:6] == 2'b10);
   assign bad3     = (lead == LEAD_E0 && (sec < E0_MIN || sec > CONT_MAX)) ||
                     (lead == LEAD_ED && sec > ED_MAX);
   assign bad4     = (lead == LEAD_F0 && (sec < F0_MIN || sec > CONT_MAX)) ||
                     (lead == LEAD_F4 && (sec < CONT_MIN || sec > F4_MAX));
   assign in_res   = idle_decode(b, fb_ff, repl_ff);
   assign held_res = idle_decode(held_ff, fb_ff, repl_ff);

   always_comb begin
      case (idx_ff)
         2'd0:    rep_byte = pend_ff[0];
         2'd1:    rep_byte = pend_ff[1];
         default: rep_byte = pend_ff[2];
      endcase
   end

   assign sts.out_free    = !out_valid_ff || rsp_ready;
   assign sts.tail_emits  = held_res.emit;
   assign sts.replay_last = (idx_ff == cnt_ff - 2'd1);
   assign sts.need_replay = (cnt_ff != 2'd0) &&
                            (!cont || (cnt_ff == 2'd2 && lead[7:4] == 4'he && bad3) ||
                             (cnt_ff == 2'd3 && bad4));

   always_comb begin
      fb_in        = fb_ff;
      repl_in      = repl_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FALLBACK: fb_in   = csr_wdata[0];
            CSR_REPL:     repl_in = csr_wdata;
            default:      ;
         endcase
      end

      if (cmd.take) begin
         out_kind_in = KIND_PRINT;
         out_last_in = 1'b1;
         case (cnt_ff)
            2'd0: begin
               out_valid_in = in_res.emit;
               out_kind_in  = in_res.kind;
               out_code_in  = in_res.code;
               if (in_res.lead) begin
                  pend_in[0] = b;
                  cnt_in     = 2'd1;
               end
            end
            2'd1: begin
               if (lead[7:5] == 3'b110) begin
                  out_valid_in = 1'b1;
                  out_code_in  = {10'd0, lead[4:0], b[5:0]};
                  cnt_in       = 2'd0;
               end else begin
                  pend_in[1] = b;
                  cnt_in     = 2'd2;
               end
            end
            2'd2: begin
               if (lead[7:4] == 4'he) begin
                  out_valid_in = 1'b1;
                  out_code_in  = {5'd0, lead[3:0], sec[5:0], b[5:0]};
                  cnt_in       = 2'd0;
               end else begin
                  pend_in[2] = b;
                  cnt_in     = 2'd3;
               end
            end
            default: begin
               out_valid_in = 1'b1;
               out_code_in  = {lead[2:0], sec[5:0], pend_ff[2][5:0], b[5:0]};
               cnt_in       = 2'd0;
            end
         endcase
      end

      // hold the breaking byte until every pending byte has gone out
      if (cmd.hold) begin
         held_in = b;
         idx_in  = 2'd0;
      end

      if (cmd.replay) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_PRINT;
         out_code_in  = invalid_code(rep_byte, fb_ff, repl_ff);
         out_last_in  = sts.replay_last && !held_res.emit;
         if (sts.replay_last) begin
            cnt_in = held_res.lead ? 2'd1 : 2'd0;
            if (held_res.lead) begin
               pend_in[0] = held_ff;
            end
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end

      if (cmd.tail) begin
         out_valid_in = 1'b1;
         out_kind_in  = held_res.kind;
         out_code_in  = held_res.code;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff        <= 1'b0;
         repl_ff      <= REPL_RESET;
         cnt_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         fb_ff        <= fb_in;
         repl_ff      <= repl_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      held_ff     <= held_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_code  = out_code_ff;
   assign rsp_last  = out_last_ff;

endmodule

FILE: rtl/utf8_stream_decoder_core.sv
// Results are registered: a result shows in the cycle after its byte is accepted.
// Throughput: one byte per cycle while sequences stay well formed and the output is not stalled.
// A byte that breaks a sequence holds the input while each pending byte is replayed and
// while its own result, if any, goes out; the shared output register sets this.
// Reset (synchronous, active high) empties the pending sequence and the output register
// and restores fallback off and replacement code 63.
module utf8_stream_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [u8sd_pkg::CODE_W-1:0]   rsp_code,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [u8sd_pkg::IDX_W-1:0]    csr_index,
   input  logic [u8sd_pkg::CODE_W-1:0]   csr_wdata
);
   import u8sd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   u8sd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   u8sd_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_in_byte (req_in_byte),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_code    (rsp_code),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: rtl/u8sd_chk.sv
`include "utf8_stream_decoder_core_assert.svh"

module u8sd_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic [u8sd_pkg::CODE_W-1:0]   rsp_code,
   input logic                          rsp_last,
   input logic                          csr_ready
);
   import u8sd_pkg::*;

   // a control beat is a single small byte value and always ends its input byte
   `U8SD_ASSERT_SAME(a_ctrl_beat, clock, reset, rsp_valid && rsp_kind, rsp_code < CODE_W'(CTRL_LIMIT) && rsp_last)

   // while more beats of one byte are due, no new byte is taken
   `U8SD_ASSERT_SAME(a_busy_no_take, clock, reset, rsp_valid && !rsp_last, !req_ready)

   `U8SD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code) && $stable(rsp_last))

   `U8SD_ASSERT_SAME(a_csr_open, clock, reset, 1'b1, csr_ready)

endmodule

bind utf8_stream_decoder_core u8sd_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_kind  (rsp_kind),
   .rsp_code  (rsp_code),
   .rsp_last  (rsp_last),
   .csr_ready (csr_ready)
);
